### rtl/bpts_pkg.sv
// Shared types and constants for the best-performance target selector.
package bpts_pkg;

    // Field widths of the request and of the table entries
    localparam int SPACE_W = 48;
    localparam int BW_W    = 20;
    localparam int LAT_W   = 24;
    localparam int SCORE_W = 16;
    localparam int EIDX_W  = 4;
    localparam int COUNT_W = 5;
    localparam int KEY_W   = LAT_W + 1;

    // Configuration port geometry
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // Reset value of the size threshold for bandwidth ranking
    localparam logic [SPACE_W-1:0] THRESH_RESET = 48'd32768;

    // Request modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PLACE = 1'b1;

    // Configuration register indexes, in address order
    typedef enum logic {
        REG_TARGET_COUNT      = 1'b0,
        REG_LATENCY_THRESHOLD = 1'b1
    } t_reg;

    // One stored target
    typedef struct packed {
        logic [SPACE_W-1:0] free_space;
        logic [BW_W-1:0]    write_bandwidth;
        logic [LAT_W-1:0]   read_latency;
        logic [LAT_W-1:0]   write_latency;
        logic [SCORE_W-1:0] entry_score;
    } t_entry;

    // Payload of one input request
    typedef struct packed {
        logic               mode;
        logic [EIDX_W-1:0]  entry_index;
        logic [SPACE_W-1:0] free_space;
        logic [BW_W-1:0]    write_bandwidth;
        logic [LAT_W-1:0]   read_latency;
        logic [LAT_W-1:0]   write_latency;
        logic [SCORE_W-1:0] entry_score;
        logic [SCORE_W-1:0] item_score;
        logic [SPACE_W-1:0] item_size;
    } t_req;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/bpts_if.sv
// Valid/ready channel interfaces for requests and placement results.
interface bpts_in_if
    import bpts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [EIDX_W-1:0]  entry_index;
    logic [SPACE_W-1:0] free_space;
    logic [BW_W-1:0]    write_bandwidth;
    logic [LAT_W-1:0]   read_latency;
    logic [LAT_W-1:0]   write_latency;
    logic [SCORE_W-1:0] entry_score;
    logic [SCORE_W-1:0] item_score;
    logic [SPACE_W-1:0] item_size;

    modport source (
        output valid, mode, entry_index, free_space, write_bandwidth, read_latency,
               write_latency, entry_score, item_score, item_size,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, free_space, write_bandwidth, read_latency,
               write_latency, entry_score, item_score, item_size,
        output ready
    );
endinterface

interface bpts_out_if
    import bpts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic [EIDX_W-1:0] chosen_index;

    modport source (
        output valid, found, chosen_index,
        input  ready
    );
    modport sink (
        input  valid, found, chosen_index,
        output ready
    );
endinterface

### rtl/bpts_ctrl.sv
// Controller state machine: sequences table writes, the table scan and the result.
module bpts_ctrl
    import bpts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_mode,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/bpts_dp.sv
// Datapath: target table memory, ranking compare, running best and output register.
module bpts_dp
    import bpts_pkg::*;
#(
    parameter int MAX_TARGETS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_req               i_req,
    input  logic [COUNT_W-1:0] i_target_count,
    input  logic [SPACE_W-1:0] i_latency_threshold,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_found,
    output logic [EIDX_W-1:0]  o_chosen_index
);

    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W = $clog2(MAX_TARGETS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Target table
    t_entry r_mem [MAX_TARGETS];

    // Request context latched at start
    logic [SPACE_W-1:0] r_size;
    logic [SCORE_W-1:0] r_blob;
    logic               r_by_bw;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_addr;

    // Registered read port
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_vld;

    // Running selection
    logic               r_have_best;
    logic [KEY_W-1:0]   r_best_key;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_have_fit;
    logic [KEY_W-1:0]   r_fit_key;
    logic [IDX_W-1:0]   r_fit_idx;

    // Output register
    logic               r_out_valid;
    logic               r_out_found;
    logic [EIDX_W-1:0]  r_out_idx;

    logic               wr_ok;
    logic [IDX_W-1:0]   wr_idx;
    logic [CMP_W-1:0]   cnt_req;
    logic [CMP_W-1:0]   cnt_max;
    logic [KEY_W-1:0]   lat_sum;
    logic [KEY_W-1:0]   key;
    logic               elig;
    logic               take_best;
    logic               take_fit;
    logic [IDX_W-1:0]   pick_idx;

    // Writes to an index at or beyond MAX_TARGETS are dropped
    assign wr_ok  = (32'(i_req.entry_index) < 32'(MAX_TARGETS));
    assign wr_idx = IDX_W'(i_req.entry_index);

    // Clamp the configured count to the table size
    assign cnt_req = CMP_W'(i_target_count);
    assign cnt_max = CMP_W'(MAX_TARGETS);

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            r_mem[wr_idx] <= '{free_space:      i_req.free_space,
                               write_bandwidth: i_req.write_bandwidth,
                               read_latency:    i_req.read_latency,
                               write_latency:   i_req.write_latency,
                               entry_score:     i_req.entry_score};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
            r_rd_idx  <= r_addr[IDX_W-1:0];
        end
    end

    // Request context and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_size  <= i_req.item_size;
            r_blob  <= i_req.item_score;
            r_by_bw <= (i_req.item_size >= i_latency_threshold);
            r_count <= CNT_W'((cnt_req > cnt_max) ? cnt_max : cnt_req);
            r_addr  <= '0;
        end else if (i_cmd.issue) begin
            r_addr  <= r_addr + CNT_W'(1);
        end
    end

    assign o_sts.scan_done = (r_addr >= r_count);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Rank key: larger is better, bandwidth as is, latency sum inverted
    assign lat_sum   = KEY_W'(r_rd_data.read_latency) + KEY_W'(r_rd_data.write_latency);
    assign key       = r_by_bw ? KEY_W'(r_rd_data.write_bandwidth) : ~lat_sum;
    assign elig      = r_rd_vld && (r_rd_data.free_space >= r_size);
    assign take_best = elig && (!r_have_best || (key > r_best_key));
    assign take_fit  = elig && (r_rd_data.entry_score <= r_blob)
                       && (!r_have_fit || (key > r_fit_key));

    // Keys and indexes of the running best and best fitting target
    always_ff @(posedge i_clk) begin
        if (take_best) begin
            r_best_key <= key;
            r_best_idx <= r_rd_idx;
        end
        if (take_fit) begin
            r_fit_key <= key;
            r_fit_idx <= r_rd_idx;
        end
    end

    // Control flags of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_have_fit  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_have_best <= 1'b0;
                r_have_fit  <= 1'b0;
            end else begin
                if (take_best) begin
                    r_have_best <= 1'b1;
                end
                if (take_fit) begin
                    r_have_fit <= 1'b1;
                end
            end
        end
    end

    // Fall back to the best eligible target when none fits the score
    assign pick_idx = r_have_fit ? r_fit_idx : r_best_idx;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_found <= r_have_best;
            r_out_idx   <= r_have_best ? EIDX_W'(pick_idx) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_chosen_index = r_out_idx;

endmodule

### rtl/best_performance_target_select.sv
// A table write gives no result.
// A placement scans one table entry per cycle through the registered read port of the
// table memory, count entries in all, count being target_count clamped to MAX_TARGETS;
// no new request is taken until its result has been loaded into the output register.
// Reset clears the controller state and the output valid flag, and sets the configuration
// registers to their reset values; table entries are undefined until written.
module best_performance_target_select
    import bpts_pkg::*;
#(
    parameter int MAX_TARGETS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    bpts_in_if.sink               i_in,
    bpts_out_if.source            o_out
);

    logic [COUNT_W-1:0] r_target_count;
    logic [SPACE_W-1:0] r_latency_threshold;
    logic               cfg_wr;
    logic               reg_sel;
    t_req               w_req;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_in_ready;

    // Configuration registers: 8-byte stride, always ready
    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count      <= '0;
            r_latency_threshold <= THRESH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TARGET_COUNT:      r_target_count      <= pwdata[COUNT_W-1:0];
                REG_LATENCY_THRESHOLD: r_latency_threshold <= pwdata[SPACE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_sel)
            REG_TARGET_COUNT:      prdata = APB_DATA_W'(r_target_count);
            REG_LATENCY_THRESHOLD: prdata = APB_DATA_W'(r_latency_threshold);
            default:               prdata = '0;
        endcase
    end

    // Gather the request payload
    assign w_req = '{mode:            i_in.mode,
                     entry_index:     i_in.entry_index,
                     free_space:      i_in.free_space,
                     write_bandwidth: i_in.write_bandwidth,
                     read_latency:    i_in.read_latency,
                     write_latency:   i_in.write_latency,
                     entry_score:     i_in.entry_score,
                     item_score:      i_in.item_score,
                     item_size:       i_in.item_size};

    assign i_in.ready = w_in_ready;

    bpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpts_dp #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_req               (w_req),
        .i_target_count      (r_target_count),
        .i_latency_threshold (r_latency_threshold),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_found             (o_out.found),
        .o_chosen_index      (o_out.chosen_index)
    );

endmodule

### sim/testbench.sv
// Self-checking testbench for the best-performance storage target selector.
module testbench;
    import bpts_pkg::*;

    localparam int N_ENTRIES = 16;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int DRAIN_CYCLES = 25;
    localparam int MAX_REPORTS = 10;
    localparam logic [SPACE_W-1:0] SPACE_MAX = '1;
    localparam logic [BW_W-1:0] BW_MAX = '1;
    localparam logic [LAT_W-1:0] LAT_MAX = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } t_row_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_LIGHT
    } t_stall;

    // One placement answer
    typedef struct packed {
        logic              found;
        logic [EIDX_W-1:0] index;
    } t_pick;

    // One line of the directed stimulus
    typedef struct {
        t_row_kind         kind;
        t_reg              which;
        logic [APB_DATA_W-1:0] value;
        t_req              req;
        logic              pinned;
        t_pick             pick;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bpts_in_if  req_if();
    bpts_out_if res_if();

    // Shadow copy of the target table and the configuration
    t_entry             shadow_table [N_ENTRIES];
    logic [COUNT_W-1:0] cfg_count;
    logic [SPACE_W-1:0] cfg_threshold;

    // Answers still owed by the block, oldest first
    t_pick placement_q[$];
    t_row  directed_rows[$];

    // Expectation typed into the directed table travels with its request
    logic  pin_valid;
    t_pick pin_pick;

    int unsigned burst_left;
    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned placements_taken;
    int unsigned results_seen;
    int unsigned settings_used;

    t_stall     stall_mode;
    int unsigned stall_left;
    logic [1:0] stall_phase;

    best_performance_target_select #(
        .MAX_TARGETS(N_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Entry a beats entry b: higher bandwidth, or lower latency sum at 25 bits.
    function automatic logic outranks(input int unsigned a, input int unsigned b,
                                      input logic by_bw);
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        if (by_bw) begin
            return shadow_table[a].write_bandwidth > shadow_table[b].write_bandwidth;
        end
        key_a = KEY_W'(shadow_table[a].read_latency) + KEY_W'(shadow_table[a].write_latency);
        key_b = KEY_W'(shadow_table[b].read_latency) + KEY_W'(shadow_table[b].write_latency);
        return key_a < key_b;
    endfunction

    // Best-ranked eligible target whose score fits the blob, else best eligible.
    function automatic t_pick pick_target(input logic [SPACE_W-1:0] size,
                                          input logic [SCORE_W-1:0] blob);
        int unsigned used;
        int unsigned best;
        int unsigned fit;
        logic        by_bw;
        logic        have_best;
        logic        have_fit;
        t_pick       pick;
        used = (cfg_count > N_ENTRIES) ? N_ENTRIES : cfg_count;
        by_bw = (size >= cfg_threshold);
        have_best = 1'b0;
        have_fit = 1'b0;
        best = 0;
        fit = 0;
        for (int unsigned i = 0; i < used; i++) begin
            if (shadow_table[i].free_space >= size) begin
                if (!have_best || outranks(i, best, by_bw)) begin
                    best = i;
                    have_best = 1'b1;
                end
                if (shadow_table[i].entry_score <= blob &&
                    (!have_fit || outranks(i, fit, by_bw))) begin
                    fit = i;
                    have_fit = 1'b1;
                end
            end
        end
        pick.found = have_best;
        pick.index = !have_best ? '0 : have_fit ? EIDX_W'(fit) : EIDX_W'(best);
        return pick;
    endfunction

    function automatic logic [SPACE_W-1:0] rand48();
        return {16'($urandom), $urandom()};
    endfunction

    // Every field random, so that ignored fields toggle too.
    function automatic t_req random_fields();
        t_req r;
        r.mode = 1'($urandom);
        r.entry_index = EIDX_W'($urandom);
        r.free_space = rand48();
        r.write_bandwidth = BW_W'($urandom);
        r.read_latency = LAT_W'($urandom);
        r.write_latency = LAT_W'($urandom);
        r.entry_score = SCORE_W'($urandom);
        r.item_score = SCORE_W'($urandom);
        r.item_size = rand48();
        return r;
    endfunction

    // Table write biased toward ties and round sizes.
    function automatic t_req random_write();
        t_req r;
        r = random_fields();
        r.mode = MODE_WRITE;
        case ($urandom_range(0, 3))
            0: r.free_space = rand48();
            1: r.free_space = SPACE_W'($urandom_range(0, 4096));
            2: r.free_space = SPACE_MAX;
            default: r.free_space = SPACE_W'($urandom_range(0, 15)) << 10;
        endcase
        if ($urandom_range(0, 1) == 0) r.write_bandwidth = BW_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) r.read_latency = LAT_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) r.write_latency = LAT_W'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0: r.entry_score = SCORE_W'($urandom_range(0, 32768));
            1: r.entry_score = ($urandom_range(0, 1) == 0) ? SCORE_W'(0) : SCORE_W'(32768);
            default: ;
        endcase
        return r;
    endfunction

    // Placement sized around stored free space and the threshold.
    function automatic t_req random_place();
        t_req r;
        logic [EIDX_W-1:0] near;
        r = random_fields();
        r.mode = MODE_PLACE;
        near = EIDX_W'($urandom);
        case ($urandom_range(0, 6))
            0: r.item_size = '0;
            1: r.item_size = rand48();
            2: r.item_size = shadow_table[near].free_space;
            3: r.item_size = shadow_table[near].free_space + SPACE_W'(1);
            4: r.item_size = cfg_threshold - SPACE_W'($urandom_range(0, 1));
            5: r.item_size = SPACE_MAX;
            default: r.item_size = SPACE_W'($urandom_range(0, 4096));
        endcase
        near = EIDX_W'($urandom);
        case ($urandom_range(0, 3))
            0: r.item_score = shadow_table[near].entry_score;
            1: r.item_score = SCORE_W'($urandom_range(0, 32768));
            2: r.item_score = ($urandom_range(0, 1) == 0) ? SCORE_W'(0) : SCORE_MAX;
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_entry(input logic [EIDX_W-1:0] idx,
                                      input logic [SPACE_W-1:0] space,
                                      input logic [BW_W-1:0] bw,
                                      input logic [LAT_W-1:0] rd_lat,
                                      input logic [LAT_W-1:0] wr_lat,
                                      input logic [SCORE_W-1:0] score);
        t_row row;
        row.kind = ROW_REQUEST;
        row.which = REG_TARGET_COUNT;
        row.value = '0;
        row.req = '0;
        row.req.mode = MODE_WRITE;
        row.req.entry_index = idx;
        row.req.free_space = space;
        row.req.write_bandwidth = bw;
        row.req.read_latency = rd_lat;
        row.req.write_latency = wr_lat;
        row.req.entry_score = score;
        row.pinned = 1'b0;
        row.pick = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_place(input logic [SPACE_W-1:0] size,
                                      input logic [SCORE_W-1:0] blob,
                                      input logic pinned,
                                      input logic found,
                                      input logic [EIDX_W-1:0] idx);
        t_row row;
        row.kind = ROW_REQUEST;
        row.which = REG_TARGET_COUNT;
        row.value = '0;
        row.req = '0;
        row.req.mode = MODE_PLACE;
        row.req.item_size = size;
        row.req.item_score = blob;
        row.pinned = pinned;
        row.pick.found = found;
        row.pick.index = idx;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_config(input t_reg which, input logic [APB_DATA_W-1:0] value);
        t_row row;
        row.kind = ROW_CONFIG;
        row.which = which;
        row.value = value;
        row.req = '0;
        row.pinned = 1'b0;
        row.pick = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offer one request, starting a new burst after a random gap when the last one ran out.
    task automatic send_request(input t_req r, input logic pinned, input t_pick pick);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= r.mode;
        req_if.entry_index <= r.entry_index;
        req_if.free_space <= r.free_space;
        req_if.write_bandwidth <= r.write_bandwidth;
        req_if.read_latency <= r.read_latency;
        req_if.write_latency <= r.write_latency;
        req_if.entry_score <= r.entry_score;
        req_if.item_score <= r.item_score;
        req_if.item_size <= r.item_size;
        pin_valid <= pinned;
        pin_pick <= pick;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
        requests_sent++;
    endtask

    // Stop sending and let every owed answer come back before touching registers.
    task automatic settle();
        req_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg which, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(int'(which) * 8);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == REG_TARGET_COUNT) begin
            cfg_count = value[COUNT_W-1:0];
        end else begin
            cfg_threshold = value[SPACE_W-1:0];
        end
    endtask

    task automatic note_mismatch(input string what, input t_pick want, input t_pick got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH %s: expected found=%0d index=%0d, got found=%0d index=%0d",
                     what, want.found, want.index, got.found, got.index);
        end
    endtask

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE: res_if.ready <= 1'b1;
            STALL_COIN: res_if.ready <= 1'($urandom);
            STALL_PERIODIC: res_if.ready <= (stall_phase == 2'd0);
            default: res_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
        stall_phase <= stall_phase + 2'd1;
    end

    // Check answers, then track writes and predict placements as requests are taken.
    always @(posedge i_clk) begin
        t_pick got;
        t_pick want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.found = res_if.found;
                got.index = res_if.chosen_index;
                results_seen++;
                if (placement_q.size() == 0) begin
                    note_mismatch("answer with no placement pending", '0, got);
                end else begin
                    want = placement_q.pop_front();
                    if (want.found !== got.found) begin
                        note_mismatch("found", want, got);
                    end else if (want.index !== got.index) begin
                        note_mismatch("chosen_index", want, got);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                if (req_if.mode == MODE_WRITE) begin
                    shadow_table[req_if.entry_index].free_space = req_if.free_space;
                    shadow_table[req_if.entry_index].write_bandwidth = req_if.write_bandwidth;
                    shadow_table[req_if.entry_index].read_latency = req_if.read_latency;
                    shadow_table[req_if.entry_index].write_latency = req_if.write_latency;
                    shadow_table[req_if.entry_index].entry_score = req_if.entry_score;
                end else begin
                    placements_taken++;
                    want = pin_valid ? pin_pick
                                     : pick_target(req_if.item_size, req_if.item_score);
                    placement_q.insert(placement_q.size(), want);
                end
            end
        end
    end

    // Main sequence: directed table, full table fill, then random phases.
    initial begin
        t_req r;
        int unsigned count_value;
        logic [SPACE_W-1:0] thresh_value;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_WRITE;
        req_if.entry_index = '0;
        req_if.free_space = '0;
        req_if.write_bandwidth = '0;
        req_if.read_latency = '0;
        req_if.write_latency = '0;
        req_if.entry_score = '0;
        req_if.item_score = '0;
        req_if.item_size = '0;
        res_if.ready = 1'b0;
        pin_valid = 1'b0;
        pin_pick = '0;
        stall_mode = STALL_NONE;
        stall_left = 0;
        stall_phase = '0;
        burst_left = 0;
        mismatches = 0;
        requests_sent = 0;
        placements_taken = 0;
        results_seen = 0;
        settings_used = 1;
        cfg_count = '0;
        cfg_threshold = THRESH_RESET;
        for (int i = 0; i < N_ENTRIES; i++) shadow_table[i] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no targets in use nothing can be found.
        add_place('0, '0, 1'b1, 1'b0, 4'd0);
        add_entry(4'd0, SPACE_MAX, '0, LAT_MAX, LAT_MAX, SCORE_MAX);
        add_entry(4'd1, '0, BW_MAX, '0, '0, '0);
        add_entry(4'd2, 48'd1000, 20'd500, 24'd10, 24'd20, 16'd32768);
        add_entry(4'd3, SPACE_MAX, BW_MAX, 24'd5, 24'd5, 16'd100);
        // Entry 4 ties entry 3 on every key, so entry 3 must win.
        add_entry(4'd4, SPACE_MAX, BW_MAX, 24'd5, 24'd5, 16'd100);
        add_config(REG_TARGET_COUNT, 64'd5);
        add_place(SPACE_MAX, SCORE_MAX, 1'b1, 1'b1, 4'd3);
        add_place('0, '0, 1'b1, 1'b1, 4'd1);
        add_place(48'd2000, 16'd50, 1'b0, 1'b0, 4'd0);
        add_place(48'd1000, 16'd32768, 1'b0, 1'b0, 4'd0);
        add_place(48'd1001, 16'd100, 1'b0, 1'b0, 4'd0);
        // Just below and exactly at the default threshold.
        add_place(48'd32767, '0, 1'b0, 1'b0, 4'd0);
        add_place(48'd32768, '0, 1'b0, 1'b0, 4'd0);
        add_config(REG_LATENCY_THRESHOLD, '0);
        add_place('0, SCORE_MAX, 1'b0, 1'b0, 4'd0);
        add_config(REG_LATENCY_THRESHOLD, 64'(SPACE_MAX));
        add_place(SPACE_MAX, '0, 1'b0, 1'b0, 4'd0);
        add_place(SPACE_MAX - 48'd1, '0, 1'b0, 1'b0, 4'd0);
        // Scores above 1.0 still compare as plain unsigned values.
        add_entry(4'd2, 48'd1001, BW_MAX, '0, '0, 16'd32769);
        add_place(48'd1000, 16'd32768, 1'b0, 1'b0, 4'd0);
        add_place(48'd1000, 16'd32769, 1'b0, 1'b0, 4'd0);
        add_config(REG_TARGET_COUNT, 64'd1);
        add_place(SPACE_MAX, '0, 1'b0, 1'b0, 4'd0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                settle();
                write_register(directed_rows[i].which, directed_rows[i].value);
                settings_used++;
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].pinned,
                             directed_rows[i].pick);
            end
        end

        // Fill every entry so that any count only reads written targets.
        for (int i = 0; i < N_ENTRIES; i++) begin
            r = random_write();
            r.entry_index = EIDX_W'(i);
            send_request(r, 1'b0, '0);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: count_value = N_ENTRIES;
                1: count_value = 31;
                2: count_value = 0;
                3: count_value = 1;
                4: count_value = N_ENTRIES + 1;
                default: count_value = $urandom_range(2, N_ENTRIES);
            endcase
            case ($urandom_range(0, 4))
                0: thresh_value = '0;
                1: thresh_value = SPACE_MAX;
                2: thresh_value = THRESH_RESET;
                3: thresh_value = rand48();
                default: thresh_value = shadow_table[EIDX_W'($urandom)].free_space;
            endcase
            settle();
            write_register(REG_TARGET_COUNT, 64'(count_value));
            write_register(REG_LATENCY_THRESHOLD, 64'(thresh_value));
            settings_used++;
            repeat (ITEMS_PER_PHASE) begin
                r = ($urandom_range(0, 9) < 3) ? random_write() : random_place();
                send_request(r, 1'b0, '0);
            end
        end

        settle();
        if (placement_q.size() != 0) begin
            mismatches += placement_q.size();
            $display("%0d placements were never answered", placement_q.size());
        end
        $display("Sent %0d requests, %0d of them placements, over %0d register settings.",
                 requests_sent, placements_taken, settings_used);
        $display("Compared %0d placement answers; %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("Timeout: the selector stopped taking requests or returning answers");
        $display("Test completed with failures");
        $finish;
    end

endmodule

### best_performance_target_select.f
rtl/bpts_pkg.sv
rtl/bpts_if.sv
rtl/bpts_ctrl.sv
rtl/bpts_dp.sv
rtl/best_performance_target_select.sv
sim/testbench.sv
